### design/rmvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmvm_pkg
// shared constants for the running mean / variance core
// ----------------------------------------------------------------------------
package rmvm_pkg;
  localparam int unsigned CountBitsDef  = 24;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned MeanW         = 32;
  localparam int unsigned VarW          = 50;
  localparam int unsigned CntOutW       = 24;
  // divider operand width: numerator n*d^2 < 2^(2*34+32)
  localparam int unsigned DivW          = 128;
  // multiplier bits walked per multiply, one a cycle
  localparam int unsigned MulW          = 64;
endpackage

### design/rmvm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmvm_div
// shared iterative unit: restoring divider with round half up, or
// shift-and-add multiplier, one bit a cycle
// ----------------------------------------------------------------------------
module rmvm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      mul_i,
  input  logic [rmvm_pkg::DivW-1:0] num_i,
  input  logic [rmvm_pkg::DivW-1:0] den_i,
  output logic                      done_o,
  output logic [rmvm_pkg::DivW-1:0] quo_o
);
  import rmvm_pkg::*;
  localparam int unsigned CW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q, den_q, quo_q, rem_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q, mul_q;
  logic [DivW:0]   shifted;
  logic [DivW:0]   trial;
  logic [DivW:0]   half_chk;

  assign shifted  = {rem_q, num_q[DivW-1]};
  assign trial    = shifted - {1'b0, den_q};
  // remainder >= den - remainder rounds up
  assign half_chk = {rem_q, 1'b0} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mul_i ? CW'(MulW) : CW'(DivW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      mul_q <= mul_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        num_q <= {num_q[DivW-2:0], 1'b0};
        if (mul_q) begin
          // multiplier in den, walked from its lowest bit
          den_q <= {1'b0, den_q[DivW-1:1]};
          if (den_q[0]) quo_q <= quo_q + num_q;
        end else if (!trial[DivW]) begin
          rem_q <= trial[DivW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= shifted[DivW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
      end else if (!mul_q && !half_chk[DivW]) begin
        quo_q <= quo_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### design/running_mean_variance_of_mean_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance_of_mean_core
// running mean, sample variance, mean of means and variance of means
// ----------------------------------------------------------------------------
// One sample in, one result out. Each item runs six divisions and six
// multiplications in turn on a single shared bit-serial unit; on the first
// sample of a series the variance steps are skipped. The core takes no new
// sample until the result transfer has completed.
module running_mean_variance_of_mean_core #(
  parameter int unsigned COUNT_BITS  = rmvm_pkg::CountBitsDef,
  parameter int unsigned FRAC_BITS   = rmvm_pkg::FracBitsDef,
  parameter int unsigned SAMPLE_BITS = rmvm_pkg::SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample
  input  logic                   s_axis_tuser,           // restart
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mean_out, variance_out, mean_of_means_out, variance_of_means_out, count_out
  output logic [191:0]           m_axis_tdata
);
  import rmvm_pkg::*;

  localparam int unsigned WW  = 64;  // signed working width for means

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMean  = 4'd1;  // divide (x-m)
  localparam logic [3:0] StMeanW = 4'd2;
  localparam logic [3:0] StV1M   = 4'd3;  // (n-2)*v
  localparam logic [3:0] StV1MW  = 4'd4;
  localparam logic [3:0] StV1    = 4'd5;  // (n-2)*v/(n-1)
  localparam logic [3:0] StV1W   = 4'd6;
  localparam logic [3:0] StSqM   = 4'd7;  // d^2
  localparam logic [3:0] StSqW   = 4'd8;
  localparam logic [3:0] StNdM   = 4'd9;  // n*d^2
  localparam logic [3:0] StNdW   = 4'd10;
  localparam logic [3:0] StV2    = 4'd11; // n*d^2/((n-1)^2 2^F)
  localparam logic [3:0] StV2W   = 4'd12;
  localparam logic [3:0] StNext  = 4'd13;
  localparam logic [3:0] StOut   = 4'd14;

  logic [3:0]            state_q, state_d;
  logic                  pass_q;     // 0: sample stats, 1: means stats
  logic [COUNT_BITS-1:0] cnt_q;
  logic signed [MeanW-1:0] mean_q, mom_q;
  logic [VarW-1:0]       var_q, vom_q;
  logic signed [WW-1:0]  x_q;        // operand: sample or new mean
  logic [VarW:0]         t1_q;       // first variance term, top bit = overflow
  logic                  neg_q;
  logic signed [WW-1:0]  diff;
  logic [WW-1:0]         adiff;
  logic [DivW-1:0]       div_num, div_den;
  logic [DivW-1:0]       quo;
  logic                  div_start, div_mul, div_done;
  logic [COUNT_BITS-1:0] n_m1;
  logic [2*COUNT_BITS-1:0] n_m1_sq;
  logic signed [WW-1:0]  new_mean;
  logic [DivW:0]         vsum;
  logic [VarW-1:0]       vres;
  logic signed [MeanW-1:0] cur_mean;
  logic [VarW-1:0]       cur_var;
  logic [COUNT_BITS-1:0] cmax;

  assign cmax     = '1;
  assign n_m1     = cnt_q - 1'b1;
  assign n_m1_sq  = n_m1 * n_m1;
  assign cur_mean = pass_q ? mom_q : mean_q;
  assign cur_var  = pass_q ? vom_q : var_q;
  assign diff     = x_q - WW'(cur_mean);
  assign adiff    = diff[WW-1] ? WW'(-diff) : WW'(diff);

  // one shared unit for all divisions and products
  rmvm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mul_i   (div_mul),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // the unit holds its last result, so a chained step takes it as operand
  always_comb begin
    div_start = 1'b0;
    div_mul   = 1'b0;
    div_num   = quo;
    div_den   = DivW'(cnt_q);
    unique case (state_q)
      StMean: begin
        div_start = 1'b1;
        div_num   = DivW'(adiff);
      end
      StV1M: begin
        div_start = 1'b1;
        div_mul   = 1'b1;
        div_num   = DivW'(cur_var);
        div_den   = DivW'(cnt_q - 2'd2);
      end
      StV1: begin
        div_start = 1'b1;
        div_den   = DivW'(n_m1);
      end
      StSqM: begin
        div_start = 1'b1;
        div_mul   = 1'b1;
        div_num   = DivW'(adiff);
        div_den   = DivW'(adiff);
      end
      StNdM: begin
        div_start = 1'b1;
        div_mul   = 1'b1;
      end
      StV2: begin
        div_start = 1'b1;
        div_den   = DivW'(n_m1_sq) << FRAC_BITS;
      end
      default: ;
    endcase
  end

  // saturate rounded mean update
  always_comb begin
    new_mean = WW'(cur_mean) + (neg_q ? -$signed(quo[WW-1:0]) : $signed(quo[WW-1:0]));
    if (new_mean > WW'(32'sh7FFF_FFFF)) new_mean = WW'(32'sh7FFF_FFFF);
    else if (new_mean < -WW'(64'sh8000_0000)) new_mean = -WW'(64'sh8000_0000);
  end

  always_comb begin
    vsum = {1'b0, quo} + DivW'(t1_q);
    if (t1_q[VarW] || vsum > DivW'({VarW{1'b1}})) vres = '1;
    else vres = vsum[VarW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StMean;
      StMean:  state_d = StMeanW;
      StMeanW: if (div_done) state_d = (cnt_q <= 1) ? StNext : StV1M;
      StV1M:   state_d = StV1MW;
      StV1MW:  if (div_done) state_d = StV1;
      StV1:    state_d = StV1W;
      StV1W:   if (div_done) state_d = StSqM;
      StSqM:   state_d = StSqW;
      StSqW:   if (div_done) state_d = StNdM;
      StNdM:   state_d = StNdW;
      StNdW:   if (div_done) state_d = StV2;
      StV2:    state_d = StV2W;
      StV2W:   if (div_done) state_d = StNext;
      StNext:  state_d = pass_q ? StOut : StMean;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
      mean_q  <= '0;
      var_q   <= '0;
      mom_q   <= '0;
      vom_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: if (s_axis_tvalid) begin
          pass_q <= 1'b0;
          if (s_axis_tuser) cnt_q <= COUNT_BITS'(1);
          else if (cnt_q != cmax) cnt_q <= cnt_q + 1'b1;
        end
        StMeanW: if (div_done) begin
          if (pass_q) mom_q <= new_mean[MeanW-1:0];
          else mean_q <= new_mean[MeanW-1:0];
          if (cnt_q <= 1) begin
            if (pass_q) vom_q <= '0;
            else var_q <= '0;
          end
        end
        StV2W: if (div_done) begin
          if (pass_q) vom_q <= vres;
          else var_q <= vres;
        end
        StNext: pass_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload-side registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      x_q <= WW'($signed(s_axis_tdata[SAMPLE_BITS-1:0])) <<< FRAC_BITS;
    end else if (state_q == StNext) begin
      x_q <= WW'(mean_q);
    end
    if (state_q == StMean) neg_q <= diff[WW-1];
    if (state_q == StV1W && div_done) begin
      t1_q <= (quo > DivW'({VarW{1'b1}})) ? {1'b1, {VarW{1'b0}}} : {1'b0, quo[VarW-1:0]};
    end
  end

  logic [CntOutW-1:0] cnt_out;
  assign cnt_out = (COUNT_BITS > CntOutW && cnt_q > COUNT_BITS'({CntOutW{1'b1}})) ?
                   '1 : CntOutW'(cnt_q);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {4'd0, cnt_out, vom_q, mom_q, var_q, mean_q};
endmodule

### design/rmvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmvm_checker
// port-level checks for the running mean / variance core
// ----------------------------------------------------------------------------
module rmvm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);
  // never ready for input while a result is held
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
  // accepted input is followed by busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("not busy");
  // result cannot come right after accept
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
  // result stalls hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind running_mean_variance_of_mean_core rmvm_checker u_rmvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the running mean / variance of means core
// ----------------------------------------------------------------------------
// Gyro samples are sent on the slave stream and each statistics transfer is
// compared, field by field, against an in-bench fixed-point predictor. The
// bench starts with a short directed table and then sends random series with
// occasional restarts. Both stream sides idle at random, and once the
// receiver holds off for a long stretch so that the core stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import rmvm_pkg::*;

  localparam logic [63:0] VarSat = (64'd1 << VarW) - 64'd1;
  localparam logic [63:0] CntSat = (64'd1 << CountBitsDef) - 64'd1;
  localparam int          NumRandom = 1630;

  // first member sits in the top bits, so mean lands lowest as on the port
  typedef struct packed {
    logic [CntOutW-1:0] count;
    logic [VarW-1:0]    variance_of_means;
    logic [MeanW-1:0]   mean_of_means;
    logic [VarW-1:0]    variance;
    logic [MeanW-1:0]   mean;
  } stats_t;

  typedef struct {
    logic [15:0] sample;
    logic        restart;
    logic        typed;   // expected value written in the row
    stats_t      stats;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;   // sample
  logic         s_axis_tuser;   // restart
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // mean, variance, mean of means, variance of means, count, zero padding
  logic [191:0] m_axis_tdata;

  // predictor state
  logic [63:0]        pred_count;
  logic signed [63:0] pred_mean;
  logic [63:0]        pred_var;
  logic signed [63:0] pred_mom;
  logic [63:0]        pred_vom;

  stats_t      stats_q[$];
  int          error_count;
  int          results_seen;
  int          items_sent;
  int          hold_cycles;
  bit          hold_done;
  bit          quiet;        // no idling on either side while set
  stim_row_t   directed[$];

  running_mean_variance_of_mean_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // unsigned division rounded to nearest, ties up
  function automatic logic [127:0] div_rounded(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    logic [127:0] r;
    q = num / den;
    r = num - q * den;
    if (r >= den - r) q = q + 128'd1;
    return q;
  endfunction

  // mean step with ties away from zero and 32-bit saturation
  function automatic logic signed [63:0] mean_step(logic signed [63:0] m,
                                                   logic signed [63:0] x,
                                                   logic [63:0] n);
    logic signed [63:0] diff;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic signed [63:0] res;
    diff = x - m;
    mag  = diff < 0 ? -diff : diff;
    q    = (mag + n / 64'd2) / n;
    res  = diff < 0 ? m - $signed(q) : m + $signed(q);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res;
  endfunction

  // sample variance step, two terms rounded separately then summed
  function automatic logic [63:0] var_step(logic [63:0] v, logic signed [63:0] d,
                                           logic [63:0] n);
    logic [127:0] t1;
    logic [127:0] t2;
    logic [127:0] mag;
    logic [127:0] den;
    logic [127:0] sum;
    if (n <= 64'd1) return 64'd0;
    t1  = div_rounded(128'(n - 64'd2) * 128'(v), 128'(n - 64'd1));
    mag = 128'(d < 0 ? -d : d);
    den = (128'(n - 64'd1) * 128'(n - 64'd1)) << FracBitsDef;
    t2  = div_rounded(mag * mag * 128'(n), den);
    if (t1 > 128'(VarSat) || t2 > 128'(VarSat)) return VarSat;
    sum = t1 + t2;
    return sum > 128'(VarSat) ? VarSat : sum[63:0];
  endfunction

  // advance the predictor by one sample and return the statistics it gives
  function automatic stats_t predict_stats(logic [15:0] sample, logic restart);
    logic signed [63:0] x;
    stats_t             s;
    x = 64'($signed(sample)) <<< FracBitsDef;
    if (restart) pred_count = 64'd1;
    else if (pred_count < CntSat) pred_count = pred_count + 64'd1;
    pred_mean = mean_step(pred_mean, x, pred_count);
    pred_var  = var_step(pred_var, x - pred_mean, pred_count);
    pred_mom  = mean_step(pred_mom, pred_mean, pred_count);
    pred_vom  = var_step(pred_vom, pred_mean - pred_mom, pred_count);
    s.mean              = pred_mean[31:0];
    s.variance          = pred_var[VarW-1:0];
    s.mean_of_means     = pred_mom[31:0];
    s.variance_of_means = pred_vom[VarW-1:0];
    s.count             = pred_count > 64'hFFFFFF ? 24'hFFFFFF : pred_count[23:0];
    return s;
  endfunction

  // one sample transfer; valid stays high across back-to-back transfers
  task automatic send_sample(logic [15:0] sample, logic restart, logic typed,
                             stats_t typed_stats);
    stats_t s;
    while (!quiet && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    s = predict_stats(sample, restart);
    stats_q.push_back(typed ? typed_stats : s);
    items_sent++;
  endtask

  function automatic stim_row_t row(logic [15:0] sample, logic restart);
    stim_row_t r;
    r.sample  = sample;
    r.restart = restart;
    r.typed   = 1'b0;
    r.stats   = '0;
    return r;
  endfunction

  // first sample of a series: mean equals the sample, variances zero
  function automatic stim_row_t first_row(logic [15:0] sample, logic restart);
    stim_row_t r;
    r = row(sample, restart);
    r.typed                   = 1'b1;
    r.stats.mean              = {sample, 16'h0000};
    r.stats.mean_of_means     = {sample, 16'h0000};
    r.stats.variance          = '0;
    r.stats.variance_of_means = '0;
    r.stats.count             = 24'd1;
    return r;
  endfunction

  // result side: check every transfer, pick ready for the next cycle
  always @(posedge clk_i) begin
    stats_t got;
    stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(stats_t)-1:0];
      results_seen++;
      if (stats_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        error_count++;
      end else begin
        want = stats_q.pop_front();
        if (got.mean !== want.mean) begin
          $display("%0t: mean exp %h act %h", $time, want.mean, got.mean);
          error_count++;
        end
        if (got.variance !== want.variance) begin
          $display("%0t: variance exp %h act %h", $time, want.variance, got.variance);
          error_count++;
        end
        if (got.mean_of_means !== want.mean_of_means) begin
          $display("%0t: mean of means exp %h act %h", $time,
                   want.mean_of_means, got.mean_of_means);
          error_count++;
        end
        if (got.variance_of_means !== want.variance_of_means) begin
          $display("%0t: variance of means exp %h act %h", $time,
                   want.variance_of_means, got.variance_of_means);
          error_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count exp %h act %h", $time, want.count, got.count);
          error_count++;
        end
      end
    end
    // long hold-off while the sender keeps offering samples
    if (!hold_done && results_seen == 300) begin
      hold_done   <= 1'b1;
      hold_cycles <= 4000;
    end
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= 23;
    end
  end

  initial begin
    logic [15:0] sample;
    logic        restart;
    int          spread;
    int          guard;
    error_count   = 0;
    results_seen  = 0;
    items_sent    = 0;
    hold_cycles   = 0;
    hold_done     = 1'b0;
    quiet         = 1'b0;
    pred_count    = '0;
    pred_mean     = '0;
    pred_var      = '0;
    pred_mom      = '0;
    pred_vom      = '0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;

    // first after reset, extremes, restarts and short series
    directed.push_back(first_row(16'h7FFF, 1'b0));
    directed.push_back(row(16'h8000, 1'b0));
    directed.push_back(row(16'h7FFF, 1'b0));
    directed.push_back(row(16'h8000, 1'b0));
    directed.push_back(row(16'h0000, 1'b0));
    directed.push_back(first_row(16'h8000, 1'b1));
    directed.push_back(row(16'h8000, 1'b0));
    directed.push_back(row(16'h8000, 1'b0));
    directed.push_back(first_row(16'h0000, 1'b1));
    directed.push_back(row(16'h0001, 1'b0));
    directed.push_back(row(16'hFFFF, 1'b0));
    directed.push_back(row(16'h0001, 1'b0));
    directed.push_back(first_row(16'hFFFF, 1'b1));
    directed.push_back(first_row(16'h5555, 1'b1));
    directed.push_back(row(16'hAAAA, 1'b0));
    directed.push_back(row(16'h7FFF, 1'b0));
    directed.push_back(row(16'h7FFF, 1'b0));
    directed.push_back(row(16'h8000, 1'b0));
    directed.push_back(first_row(16'h1234, 1'b1));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_sample(directed[i].sample, directed[i].restart, directed[i].typed,
                  directed[i].stats);

    // random series, mostly long, with occasional restarts
    spread = 32767;
    for (int i = 0; i < NumRandom; i++) begin
      quiet   = (i >= 700 && i < 950);
      restart = ($urandom_range(0, 39) == 0);
      if (restart) spread = ($urandom_range(0, 2) == 0) ? 32767 : int'($urandom_range(1, 2000));
      if (spread == 32767) sample = 16'($urandom());
      else sample = 16'($signed($urandom_range(0, 2 * spread)) - spread);
      send_sample(sample, restart, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (stats_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2000) @(posedge clk_i);
    if (error_count == 0 && stats_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (stats_q.size() != 0)
        $display("%0t: %0d results never arrived", $time, stats_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
